// ----- src/kml_pkg.sv -----
// kml_pkg: shared types and constants for the k-means pass block
// no dependencies
package kml_pkg;
	localparam logic [1:0] KIND_WR    = 2'd0;
	localparam logic [1:0] KIND_POINT = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_RD    = 2'd3;

	localparam logic [1:0] RES_READ   = 2'd0;
	localparam logic [1:0] RES_ASSIGN = 2'd1;
	localparam logic [1:0] RES_SUMMARY = 2'd2;

	localparam int MAX_CLUSTERS = 16;
	localparam int MAX_DIMS     = 32;

	localparam int CNT_W  = 20;
	localparam int DIST_W = 40;
	localparam int SUM_W  = 37;
	localparam int CONV_SHIFT = 10;

	localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	localparam logic [0:0] REG_CLUSTERS = 1'b0;
	localparam logic [0:0] REG_DIMS     = 1'b1;

	typedef struct packed {
		logic        clr;
		logic        acc;
		logic [15:0] val;
	} cell_ctl_t;
endpackage

// ----- src/kml_cell.sv -----
// kml_cell: one distance cell, keeps the partial distance of one centroid
// depends on kml_pkg
module kml_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kml_pkg::cell_ctl_t          ctl,
	input  logic                        en,
	input  logic signed [15:0]          cent,
	output logic [kml_pkg::DIST_W-1:0]  part_dist
);
	logic signed [16:0] diff;
	logic [33:0] sq;
	logic [kml_pkg::DIST_W:0] sum;
	logic [kml_pkg::DIST_W-1:0] dist_q;

	assign diff = 17'(signed'(ctl.val)) - 17'(cent);
	assign sq   = 34'(diff * diff);
	assign sum  = {1'b0, dist_q} + (kml_pkg::DIST_W+1)'(sq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
		end else if (ctl.clr) begin
			dist_q <= '0;
		end else if (ctl.acc && en) begin
			dist_q <= sum[kml_pkg::DIST_W] ? kml_pkg::DIST_MAX : sum[kml_pkg::DIST_W-1:0];
		end
	end

	assign part_dist = dist_q;
endmodule

// ----- src/kmeans_lloyd_pass.sv -----
// kmeans_lloyd_pass: one fused Lloyd k-means pass with a centroid table
// depends on kml_pkg and kml_cell
//
// Channels: input beats carry kind, cluster_index, dim_index, value,
// prev_cluster and last_coord on in_valid/in_ready; result beats leave on
// out_valid/out_ready through an output register. Config writes use
// cfg_we/cfg_index/cfg_data and apply at once.
// Write beats store the entry and return to idle; reads fetch the entry
// and then load the result. A point coordinate is buffered, then one
// centroid column is read per cycle and shifted along the cell row; the
// last coordinate adds a min search over all cell slots, a read, read and
// write per coordinate in use to fold the point into the sums, and a load.
// End of pass walks every table entry and clears its sum; each coordinate
// in use is also divided (bit-serial divider) and its centroid rewritten.
// Reset clears control state and the sum memory, with in_ready held low.
// A stalled receiver holds the result; the next beat is taken while a
// result waits, but a beat with a result to load waits until it is gone.
module kmeans_lloyd_pass (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [5:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [3:0]         cluster_index,
	input  logic [4:0]         dim_index,
	input  logic signed [15:0] value,
	input  logic [3:0]         prev_cluster,
	input  logic               last_coord,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         result_kind,
	output logic signed [15:0] read_value,
	output logic [3:0]         cluster,
	output logic [39:0]        best_distance,
	output logic               changed,
	output logic [19:0]        changed_count,
	output logic               converged
);
	localparam int MAX_CLUSTERS = kml_pkg::MAX_CLUSTERS;
	localparam int MAX_DIMS = kml_pkg::MAX_DIMS;
	localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int AW = CW + DW;
	localparam int DEPTH = MAX_CLUSTERS * MAX_DIMS;
	localparam int KW = $clog2(MAX_CLUSTERS + 1);
	localparam int NW = $clog2(MAX_DIMS + 1);
	localparam int SW = kml_pkg::SUM_W;
	localparam int QW = SW;

	localparam logic [4:0] ST_CLR   = 5'd0;
	localparam logic [4:0] ST_IDLE  = 5'd1;
	localparam logic [4:0] ST_RD    = 5'd2;
	localparam logic [4:0] ST_RD2   = 5'd3;
	localparam logic [4:0] ST_PRD   = 5'd4;
	localparam logic [4:0] ST_PSH   = 5'd5;
	localparam logic [4:0] ST_MIN   = 5'd6;
	localparam logic [4:0] ST_SRD   = 5'd7;
	localparam logic [4:0] ST_SWR   = 5'd8;
	localparam logic [4:0] ST_ERD   = 5'd9;
	localparam logic [4:0] ST_EDIV  = 5'd10;
	localparam logic [4:0] ST_EWR   = 5'd11;
	localparam logic [4:0] ST_OUT   = 5'd12;
	localparam logic [4:0] ST_SRD2  = 5'd13;
	localparam logic [4:0] ST_ERD2  = 5'd14;

	logic [4:0] state_q;

	logic [4:0] kreg_q;
	logic [5:0] dreg_q;
	logic [KW-1:0] k_eff;
	logic [NW-1:0] d_eff;

	always_comb begin
		if (kreg_q == 5'd0) k_eff = KW'(1);
		else if (32'(kreg_q) > MAX_CLUSTERS) k_eff = KW'(MAX_CLUSTERS);
		else k_eff = KW'(kreg_q);
		if (dreg_q == 6'd0) d_eff = NW'(1);
		else if (32'(dreg_q) > MAX_DIMS) d_eff = NW'(MAX_DIMS);
		else d_eff = NW'(dreg_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kreg_q <= 5'd16;
			dreg_q <= 6'd30;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kml_pkg::REG_CLUSTERS: kreg_q <= cfg_data[4:0];
				kml_pkg::REG_DIMS:     dreg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured beat
	logic [1:0]  kind_q;
	logic [3:0]  ci_q;
	logic [4:0]  di_q;
	logic signed [15:0] val_q;
	logic [3:0]  prev_q;
	logic        last_q;

	// memories
	logic signed [15:0] cent_mem [DEPTH];
	logic [SW-1:0] sum_mem [DEPTH];
	logic signed [15:0] pbuf [MAX_DIMS];
	logic [kml_pkg::CNT_W-1:0] cnt_q [MAX_CLUSTERS];

	logic cent_we;
	logic [AW-1:0] cent_wa, cent_ra;
	logic signed [15:0] cent_wd, cent_rd_q;
	logic sum_we;
	logic [AW-1:0] sum_wa, sum_ra;
	logic [SW-1:0] sum_wd, sum_rd_q;

	always_ff @(posedge clk) begin
		if (cent_we) cent_mem[cent_wa] <= cent_wd;
		cent_rd_q <= cent_mem[cent_ra];
	end

	always_ff @(posedge clk) begin
		if (sum_we) sum_mem[sum_wa] <= sum_wd;
		sum_rd_q <= sum_mem[sum_ra];
	end

	// cell row
	logic [CW-1:0] c_q;
	logic [DW-1:0] d_q;
	logic [AW:0] clr_q;
	logic signed [15:0] shift_s1 [MAX_CLUSTERS];
	logic [kml_pkg::DIST_W-1:0] cell_dist [MAX_CLUSTERS];
	kml_pkg::cell_ctl_t cctl;
	logic [CW:0] psh_q;

	always_ff @(posedge clk) begin
		shift_s1[MAX_CLUSTERS-1] <= cent_rd_q;
		for (int i = 0; i < MAX_CLUSTERS - 1; i++) shift_s1[i] <= shift_s1[i+1];
	end

	genvar g;
	generate
		for (g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
			kml_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(cctl),
				.en(32'(g) < 32'(k_eff)),
				.cent(shift_s1[g]), .part_dist(cell_dist[g])
			);
		end
	endgenerate

	// min search and bookkeeping
	logic [CW-1:0] best_q;
	logic [kml_pkg::DIST_W-1:0] bestd_q;
	logic [kml_pkg::CNT_W-1:0] pts_q, chg_q;

	// divider
	logic [QW-1:0] num_q, quo_q;
	logic [kml_pkg::CNT_W:0] rem_q;
	logic neg_q;
	logic [5:0] bit_q;
	logic [kml_pkg::CNT_W-1:0] den;
	logic [kml_pkg::CNT_W:0] rem_sh;
	logic [SW-1:0] sum_abs;
	logic signed [15:0] mean;

	assign den = cnt_q[c_q];
	assign rem_sh = {rem_q[kml_pkg::CNT_W-1:0], num_q[QW-1]};
	assign sum_abs = sum_rd_q[SW-1] ? (~sum_rd_q + SW'(1)) : sum_rd_q;

	always_comb begin
		if (den == '0) mean = '0;
		else if (neg_q) begin
			if (quo_q > QW'(32768)) mean = -16'sd32768;
			else mean = 16'(~quo_q + QW'(1));
		end else begin
			if (quo_q > QW'(32767)) mean = 16'sd32767;
			else mean = 16'(quo_q);
		end
	end

	// sum accumulate
	logic signed [SW:0] sadd;
	logic [SW-1:0] ssat;
	assign sadd = (SW+1)'(signed'(sum_rd_q)) + (SW+1)'(signed'(pbuf[d_q]));
	always_comb begin
		if (sadd[SW] != sadd[SW-1]) ssat = sadd[SW] ? {1'b1, {(SW-1){1'b0}}}
		                                            : {1'b0, {(SW-1){1'b1}}};
		else ssat = sadd[SW-1:0];
	end

	// output register
	logic out_valid_q;
	logic [1:0] rk_q;
	logic signed [15:0] rv_q;
	logic [3:0] cl_q;
	logic [39:0] bd_q;
	logic ch_q;
	logic [19:0] cc_q;
	logic cv_q;

	// end of pass walk position
	logic ent_use, ent_last, res_load;
	assign ent_use = 32'(c_q) < 32'(k_eff) && 32'(d_q) < 32'(d_eff);
	assign ent_last = 32'(c_q) == MAX_CLUSTERS - 1 && 32'(d_q) == MAX_DIMS - 1;
	assign res_load = (!out_valid_q || out_ready) && (state_q == ST_RD2
		|| state_q == ST_OUT || (state_q == ST_EWR && ent_last));

	logic take;
	assign in_ready = (state_q == ST_IDLE);
	assign take = in_valid && in_ready;

	logic [AW-1:0] acc_addr;
	assign acc_addr = {ci_q[CW-1:0], di_q[DW-1:0]};

	always_comb begin
		cent_we = 1'b0;
		cent_wa = acc_addr;
		cent_wd = val_q;
		cent_ra = acc_addr;
		sum_we = 1'b0;
		sum_wa = {c_q, d_q};
		sum_wd = ssat;
		sum_ra = {c_q, d_q};
		cctl.clr = 1'b0;
		cctl.acc = 1'b0;
		cctl.val = val_q;
		unique case (state_q)
			ST_CLR: begin
				sum_we = 1'b1;
				sum_wa = clr_q[AW-1:0];
				sum_wd = '0;
			end
			ST_RD: begin
				cent_we = (kind_q == kml_pkg::KIND_WR) && 32'(ci_q) < MAX_CLUSTERS
					&& 32'(di_q) < MAX_DIMS;
			end
			ST_PRD: cent_ra = {c_q, di_q[DW-1:0]};
			ST_PSH: begin
				cent_ra = {c_q, di_q[DW-1:0]};
				cctl.acc = (psh_q == (CW+1)'(MAX_CLUSTERS + 1)) && 32'(di_q) < 32'(d_eff);
			end
			ST_MIN: cctl.clr = (32'(c_q) == MAX_CLUSTERS - 1);
			ST_SRD, ST_SRD2: sum_ra = {best_q, d_q};
			ST_SWR: begin
				sum_we = 1'b1;
				sum_wa = {best_q, d_q};
			end
			ST_ERD: cctl.clr = 1'b1;
			ST_EWR: begin
				cent_we = ent_use;
				cent_wa = {c_q, d_q};
				cent_wd = mean;
				sum_we = 1'b1;
				sum_wd = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			c_q <= '0;
			d_q <= '0;
			psh_q <= '0;
			pts_q <= '0;
			chg_q <= '0;
			for (int i = 0; i < MAX_CLUSTERS; i++) cnt_q[i] <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + (AW+1)'(1);
					if (clr_q == (AW+1)'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (take) begin
						kind_q <= kind; ci_q <= cluster_index; di_q <= dim_index;
						val_q <= value; prev_q <= prev_cluster; last_q <= last_coord;
						c_q <= '0; d_q <= '0; psh_q <= '0;
						unique case (kind)
							kml_pkg::KIND_WR, kml_pkg::KIND_RD: state_q <= ST_RD;
							kml_pkg::KIND_POINT: state_q <= ST_PRD;
							default: state_q <= ST_ERD;
						endcase
					end
				end
				ST_RD: begin
					if (kind_q == kml_pkg::KIND_WR) state_q <= ST_IDLE;
					else state_q <= ST_RD2;
				end
				ST_RD2: begin
					if (res_load) begin
						rk_q <= kml_pkg::RES_READ;
						rv_q <= (32'(ci_q) < MAX_CLUSTERS && 32'(di_q) < MAX_DIMS)
							? cent_rd_q : '0;
						cl_q <= '0; bd_q <= '0; ch_q <= 1'b0; cc_q <= '0; cv_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_PRD: begin
					if (32'(di_q) < 32'(d_eff)) pbuf[di_q[DW-1:0]] <= val_q;
					c_q <= '0;
					psh_q <= '0;
					state_q <= ST_PSH;
				end
				ST_PSH: begin
					// read centroids from the bottom up, shift them into the row
					psh_q <= psh_q + (CW+1)'(1);
					if (psh_q == (CW+1)'(MAX_CLUSTERS + 1)) begin
						c_q <= '0;
						if (last_q) begin
							best_q <= '0;
							bestd_q <= kml_pkg::DIST_MAX;
							state_q <= ST_MIN;
						end else state_q <= ST_IDLE;
					end else c_q <= c_q + CW'(1);
				end
				ST_MIN: begin
					if (32'(c_q) < 32'(k_eff) && cell_dist[c_q] < bestd_q) begin
						bestd_q <= cell_dist[c_q];
						best_q <= c_q;
					end
					c_q <= c_q + CW'(1);
					if (32'(c_q) == MAX_CLUSTERS - 1) begin
						d_q <= '0;
						state_q <= ST_SRD;
					end
				end
				ST_SRD: state_q <= ST_SRD2;
				ST_SRD2: state_q <= ST_SWR;
				ST_SWR: begin
					if (32'(d_q) == 32'(d_eff) - 1) state_q <= ST_OUT;
					else begin
						d_q <= d_q + DW'(1);
						state_q <= ST_SRD;
					end
				end
				ST_OUT: begin
					if (res_load) begin
						rk_q <= kml_pkg::RES_ASSIGN;
						rv_q <= '0;
						cl_q <= 4'(best_q);
						bd_q <= bestd_q;
						ch_q <= 4'(best_q) != prev_q;
						cc_q <= '0; cv_q <= 1'b0;
						if (cnt_q[best_q] != kml_pkg::CNT_MAX)
							cnt_q[best_q] <= cnt_q[best_q] + 1'b1;
						if (pts_q != kml_pkg::CNT_MAX) pts_q <= pts_q + 1'b1;
						if (4'(best_q) != prev_q && chg_q != kml_pkg::CNT_MAX)
							chg_q <= chg_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_ERD: begin
					if (ent_use) state_q <= ST_ERD2;
					else state_q <= ST_EWR;
				end
				ST_ERD2: begin
					num_q <= sum_abs;
					neg_q <= sum_rd_q[SW-1];
					rem_q <= '0;
					quo_q <= '0;
					bit_q <= '0;
					state_q <= ST_EDIV;
				end
				ST_EDIV: begin
					// restoring division, one quotient bit per cycle
					num_q <= {num_q[QW-2:0], 1'b0};
					if (rem_sh >= {1'b0, den}) begin
						rem_q <= rem_sh - {1'b0, den};
						quo_q <= {quo_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[QW-2:0], 1'b0};
					end
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'(QW - 1)) state_q <= ST_EWR;
				end
				ST_EWR: begin
					if (ent_last) begin
						if (res_load) begin
							rk_q <= kml_pkg::RES_SUMMARY;
							rv_q <= '0; cl_q <= '0; bd_q <= '0; ch_q <= 1'b0;
							cc_q <= chg_q;
							cv_q <= chg_q <= (pts_q >> kml_pkg::CONV_SHIFT);
							pts_q <= '0;
							chg_q <= '0;
							for (int i = 0; i < MAX_CLUSTERS; i++) cnt_q[i] <= '0;
							c_q <= '0;
							d_q <= '0;
							state_q <= ST_IDLE;
						end
					end else if (32'(d_q) == MAX_DIMS - 1) begin
						d_q <= '0;
						c_q <= c_q + CW'(1);
						state_q <= ST_ERD;
					end else begin
						d_q <= d_q + DW'(1);
						state_q <= ST_ERD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = rk_q;
	assign read_value    = rv_q;
	assign cluster       = cl_q;
	assign best_distance = bd_q;
	assign changed       = ch_q;
	assign changed_count = cc_q;
	assign converged     = cv_q;

`ifndef SYNTH
	a_rdy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind))
		else $error("result dropped");
	a_best: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> 32'(best_q) < 32'(k_eff)) else $error("bad label");
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> !in_ready) else $error("busy in clear");
`endif
endmodule
